// ----- src/elu_pkg.sv -----
// Shared types, widths and constants of the ELU activation unit.
package elu_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int ALPHA_WIDTH = 15;
  localparam int ALPHA_FRAC  = 12;

  localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_WIDTH'(1) << ALPHA_FRAC;

  localparam int LO_W = 32;

  // exp datapath, Q1.62
  localparam int EXP_FRAC = 62;
  localparam int EXP_W    = EXP_FRAC + 1;
  localparam int E_HI_W   = EXP_W - LO_W;
  localparam logic [EXP_W-1:0] EXP_ONE = EXP_W'(1) << EXP_FRAC;

  localparam int TAYLOR_TERMS = 12;
  localparam int SQUARINGS    = 14;

  // Taylor step: p = (t * r + round) >> T_SHIFT, with r = 1.0 - q
  localparam int T_SHIFT = 14 + FRAC_BITS;
  localparam int TR_W    = DATA_WIDTH + EXP_W;
  localparam int Q_W     = TR_W - T_SHIFT;
  localparam int Q_HI_W  = Q_W - LO_W;
  localparam int TQ_LO_W = DATA_WIDTH + LO_W;
  localparam int TQ_HI_W = DATA_WIDTH + Q_HI_W;
  localparam logic [TR_W-1:0] T_ROUND = TR_W'(1) << (T_SHIFT - 1);

  // divide by a small constant through a rounded-up reciprocal
  localparam int DIV_SHIFT = 56;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int R_HI_W    = RECIP_W - LO_W;
  localparam int DIV_W     = Q_W + RECIP_W;
  localparam logic [63:0] DIV_ONE = 64'd1 << DIV_SHIFT;

  // squaring
  localparam int SQ_W    = 2 * EXP_W;
  localparam int SQ_LH_W = LO_W + E_HI_W;
  localparam int SQ_HH_W = 2 * E_HI_W;
  localparam logic [SQ_W-1:0] SQ_ROUND = SQ_W'(1) << (EXP_FRAC - 1);

  // alpha scaling
  localparam int AM_LO_W = ALPHA_WIDTH + LO_W;
  localparam int AM_HI_W = ALPHA_WIDTH + E_HI_W;
  localparam int AM_W    = ALPHA_WIDTH + EXP_W + 1;
  localparam int A_SHIFT = EXP_FRAC + ALPHA_FRAC - FRAC_BITS;
  localparam int MAG_W   = AM_W - A_SHIFT;
  localparam logic [AM_W-1:0]  A_ROUND = AM_W'(1) << (A_SHIFT - 1);
  localparam logic [MAG_W-1:0] MAG_NEG = MAG_W'(1) << (DATA_WIDTH - 1);
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_NEG - MAG_W'(1);

  localparam logic [DATA_WIDTH-1:0] Y_MAX    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam bit                    ONE_FITS = (FRAC_BITS < DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] Y_ONE    =
      ONE_FITS ? (DATA_WIDTH'(1) << FRAC_BITS) : Y_MAX;

  // input reg + Taylor + convert + squarings + scale/round/output
  localparam int LATENCY = 1 + 4 * TAYLOR_TERMS + 1 + 2 * SQUARINGS + 4;

  typedef enum logic {
    FUNC_ELU   = 1'b0,
    FUNC_DERIV = 1'b1
  } func_e;

  typedef struct packed {
    logic                          vld;
    func_e                         func;
    logic                          neg;
    logic signed [DATA_WIDTH-1:0]  x;
    logic [DATA_WIDTH-1:0]         t;
  } tag_t;

endpackage

// ----- src/elu_exp.sv -----
// Pipelined exp(-t) in Q1.62: Taylor series on t/2^(FRAC_BITS+14), then repeated squaring.
module elu_exp
  import elu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tag_t             tag_i,
  output tag_t             tag_o,
  output logic [EXP_W-1:0] exp_o
);

  tag_t             tay_tag [TAYLOR_TERMS+1];
  logic [Q_W-1:0]   tay_q   [TAYLOR_TERMS+1];
  tag_t             sq_tag  [SQUARINGS+1];
  logic [EXP_W-1:0] sq_r    [SQUARINGS+1];

  assign tay_tag[0] = tag_i;
  assign tay_q[0]   = '0;

  // each term carries q = 1.0 - r
  for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
    localparam logic [63:0]        Divisor = 64'(TAYLOR_TERMS - k);
    localparam logic [RECIP_W-1:0] Recip   =
        RECIP_W'((DIV_ONE + Divisor - 64'd1) / Divisor);

    tag_t                  tag1_q, tag2_q, tag3_q, tag4_q;
    logic [TQ_LO_W-1:0]    tq_lo_q;
    logic [TQ_HI_W-1:0]    tq_hi_q;
    logic [Q_W-1:0]        p_q;
    logic [2*LO_W-1:0]     ll_q;
    logic [LO_W+R_HI_W-1:0]   lh_q;
    logic [Q_HI_W+LO_W-1:0]   hl_q;
    logic [Q_HI_W+R_HI_W-1:0] hh_q;
    logic [Q_W-1:0]        q_q;
    logic [TR_W-1:0]       tq_d, num_d;
    logic [DIV_W-1:0]      sum_d;

    always_comb begin
      tq_d  = TR_W'(tq_lo_q) + (TR_W'(tq_hi_q) << LO_W);
      num_d = (TR_W'(tag1_q.t) << EXP_FRAC) - tq_d + T_ROUND;
      sum_d = DIV_W'(ll_q) + (DIV_W'(lh_q) << LO_W) + (DIV_W'(hl_q) << LO_W)
            + (DIV_W'(hh_q) << (2 * LO_W));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag1_q <= '0;
        tag2_q <= '0;
        tag3_q <= '0;
        tag4_q <= '0;
      end else begin
        tag1_q <= tay_tag[k];
        tag2_q <= tag1_q;
        tag3_q <= tag2_q;
        tag4_q <= tag3_q;
      end
    end

    always_ff @(posedge clk_i) begin
      tq_lo_q <= TQ_LO_W'(tay_tag[k].t) * TQ_LO_W'(tay_q[k][LO_W-1:0]);
      tq_hi_q <= TQ_HI_W'(tay_tag[k].t) * TQ_HI_W'(tay_q[k][Q_W-1:LO_W]);
      p_q     <= num_d[TR_W-1:T_SHIFT];
      ll_q    <= (2*LO_W)'(p_q[LO_W-1:0]) * (2*LO_W)'(Recip[LO_W-1:0]);
      lh_q    <= (LO_W+R_HI_W)'(p_q[LO_W-1:0]) * (LO_W+R_HI_W)'(Recip[RECIP_W-1:LO_W]);
      hl_q    <= (Q_HI_W+LO_W)'(p_q[Q_W-1:LO_W]) * (Q_HI_W+LO_W)'(Recip[LO_W-1:0]);
      hh_q    <= (Q_HI_W+R_HI_W)'(p_q[Q_W-1:LO_W])
               * (Q_HI_W+R_HI_W)'(Recip[RECIP_W-1:LO_W]);
      q_q     <= sum_d[DIV_SHIFT +: Q_W];
    end

    assign tay_tag[k+1] = tag4_q;
    assign tay_q[k+1]   = q_q;
  end

  tag_t             cv_tag_q;
  logic [EXP_W-1:0] cv_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_tag_q <= '0;
    end else begin
      cv_tag_q <= tay_tag[TAYLOR_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    cv_r_q <= EXP_ONE - EXP_W'(tay_q[TAYLOR_TERMS]);
  end

  assign sq_tag[0] = cv_tag_q;
  assign sq_r[0]   = cv_r_q;

  for (genvar s = 0; s < SQUARINGS; s++) begin : g_square
    tag_t               tag1_q, tag2_q;
    logic [2*LO_W-1:0]  ll_q;
    logic [SQ_LH_W-1:0] lh_q;
    logic [SQ_HH_W-1:0] hh_q;
    logic [EXP_W-1:0]   r_q;
    logic [SQ_W-1:0]    sum_d;

    always_comb begin
      sum_d = SQ_W'(ll_q) + (SQ_W'(lh_q) << (LO_W + 1)) + (SQ_W'(hh_q) << (2 * LO_W))
            + SQ_ROUND;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag1_q <= '0;
        tag2_q <= '0;
      end else begin
        tag1_q <= sq_tag[s];
        tag2_q <= tag1_q;
      end
    end

    always_ff @(posedge clk_i) begin
      ll_q <= (2*LO_W)'(sq_r[s][LO_W-1:0]) * (2*LO_W)'(sq_r[s][LO_W-1:0]);
      lh_q <= SQ_LH_W'(sq_r[s][LO_W-1:0]) * SQ_LH_W'(sq_r[s][EXP_W-1:LO_W]);
      hh_q <= SQ_HH_W'(sq_r[s][EXP_W-1:LO_W]) * SQ_HH_W'(sq_r[s][EXP_W-1:LO_W]);
      r_q  <= sum_d[EXP_FRAC +: EXP_W];
    end

    assign sq_tag[s+1] = tag2_q;
    assign sq_r[s+1]   = r_q;
  end

  assign tag_o = sq_tag[SQUARINGS];
  assign exp_o = sq_r[SQUARINGS];

endmodule

// ----- src/elu_activation_unit.sv -----
// ELU activation unit, forward and derivative, Q4.12 fixed point.
//
// Usage:
//   Input: drive func_i and x_value_i with start high; the beat is taken at
//   every edge where start is high and busy is low. busy stays low, so a new
//   sample can be issued every clock.
//   Output: done_o is high for exactly one cycle per sample, with y_value_o
//   and saturated_o valid in that cycle. There is no back-pressure: the
//   receiver must take every result when it is shown.
//   Config: cfg_alpha_scale_i is written when cfg_valid_i and cfg_ready_o are
//   high; cfg_ready_o is always high. Write only while no sample is in flight.
// Timing:
//   One sample per clock sustained. The pipeline depth is set by the exp
//   pipeline: 12 Taylor terms of 4 stages each and 14 squarings of 2
//   stages each, plus input, conversion and alpha scaling stages.
// Reset:
//   rst_ni clears all valid bits in the pipeline and sets alpha to 1.0.
//   Results are returned in issue order.
module elu_activation_unit
  import elu_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func_i,
  input  logic signed [DATA_WIDTH-1:0] x_value_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] y_value_o,
  output logic                         saturated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ALPHA_WIDTH-1:0]       cfg_alpha_scale_i
);

  logic [ALPHA_WIDTH-1:0] alpha_q;
  tag_t                   tag_d, tag0_q, exp_tag;
  logic [EXP_W-1:0]       exp_val;

  tag_t                   ftag1_q, ftag2_q, ftag3_q;
  logic [EXP_W-1:0]       m_q;
  logic [AM_LO_W-1:0]     am_lo_q;
  logic [AM_HI_W-1:0]     am_hi_q;
  logic [AM_W-1:0]        asum_d;
  logic [MAG_W-1:0]       mag_q, mag_c, neg_mag;

  logic                         done_q, sat_q, sat_d;
  logic signed [DATA_WIDTH-1:0] y_q, y_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alpha_q <= cfg_alpha_scale_i;
    end
  end

  always_comb begin
    tag_d.vld  = start && !busy;
    tag_d.func = func_e'(func_i);
    tag_d.neg  = x_value_i[DATA_WIDTH-1];
    tag_d.x    = x_value_i;
    tag_d.t    = DATA_WIDTH'(0) - DATA_WIDTH'(x_value_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else begin
      tag0_q <= tag_d;
    end
  end

  elu_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag0_q),
    .tag_o  (exp_tag),
    .exp_o  (exp_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ftag1_q <= '0;
      ftag2_q <= '0;
      ftag3_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ftag1_q <= exp_tag;
      ftag2_q <= ftag1_q;
      ftag3_q <= ftag2_q;
      done_q  <= ftag3_q.vld;
    end
  end

  always_comb begin
    asum_d = AM_W'(am_lo_q) + (AM_W'(am_hi_q) << LO_W) + A_ROUND;
  end

  always_ff @(posedge clk_i) begin
    m_q     <= (exp_tag.func == FUNC_DERIV) ? exp_val : (EXP_ONE - exp_val);
    am_lo_q <= AM_LO_W'(alpha_q) * AM_LO_W'(m_q[LO_W-1:0]);
    am_hi_q <= AM_HI_W'(alpha_q) * AM_HI_W'(m_q[EXP_W-1:LO_W]);
    mag_q   <= asum_d[AM_W-1:A_SHIFT];
  end

  always_comb begin
    y_d     = ftag3_q.x;
    sat_d   = 1'b0;
    mag_c   = mag_q;
    neg_mag = MAG_W'(0) - mag_q;
    if (!ftag3_q.neg) begin
      if (ftag3_q.func == FUNC_DERIV) begin
        y_d   = signed'(Y_ONE);
        sat_d = !ONE_FITS;
      end
    end else if (ftag3_q.func == FUNC_ELU) begin
      if (mag_q > MAG_NEG) begin
        mag_c = MAG_NEG;
        sat_d = 1'b1;
      end
      neg_mag = MAG_W'(0) - mag_c;
      y_d     = signed'(neg_mag[DATA_WIDTH-1:0]);
    end else begin
      if (mag_q > MAG_MAX) begin
        mag_c = MAG_MAX;
        sat_d = 1'b1;
      end
      y_d = signed'(mag_c[DATA_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    sat_q <= sat_d;
  end

  assign done_o      = done_q;
  assign y_value_o   = y_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("result beat missing after pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result beat without a matching input beat");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && func_i == FUNC_ELU && !x_value_i[DATA_WIDTH-1]) |->
      ##LATENCY (y_value_o == $past(x_value_i, LATENCY) && !saturated_o))
    else $error("non-negative forward sample not passed through");
`endif

endmodule
